// ===== hw/rtl/nds_pkg.sv =====
// nds_pkg: shared types and constants for the double-precision square root
// used by the shared floating-point unit (nds_fpu) and the top-level sequencer
`default_nettype none

package nds_pkg;

  // ieee-754 double layout
  localparam int DBL_W  = 64;
  localparam int EXP_W  = 11;
  localparam int FRAC_W = 52;
  localparam int MAN_W  = 53;

  // internal signed exponent width, wide enough for product and quotient exponents
  localparam int EW = 14;

  // shared unit operation codes
  localparam int OP_W = 3;
  typedef logic [OP_W-1:0] fpu_op_t;
  localparam fpu_op_t OP_ADD  = 3'd0;
  localparam fpu_op_t OP_SUB  = 3'd1;
  localparam fpu_op_t OP_MUL  = 3'd2;
  localparam fpu_op_t OP_DIV  = 3'd3;
  localparam fpu_op_t OP_HALF = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // bit patterns
  localparam logic [DBL_W-1:0] EXP_MASK  = 64'h7ff0000000000000;
  localparam logic [DBL_W-1:0] FRAC_MASK = 64'h000fffffffffffff;
  localparam logic [DBL_W-1:0] QUIET_NAN = 64'h7ff8000000000000;
  localparam logic [DBL_W-1:0] DBL_ONE   = 64'h3ff0000000000000;
  localparam logic [DBL_W-1:0] TOL_REL   = 64'h3eb0c6f7a0b5ed8d;  // 1e-6
  localparam logic [DBL_W-1:0] TOL_MIN   = 64'h3d719799812dea11;  // 1e-12

  // request into the shared unit
  typedef struct packed {
    logic             start;
    fpu_op_t          op;
    logic [DBL_W-1:0] a;
    logic [DBL_W-1:0] b;
  } fpu_req_t;

  // response from the shared unit
  typedef struct packed {
    logic             done;
    logic [DBL_W-1:0] res;
  } fpu_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nds_fpu.sv =====
// nds_fpu: shared iterative unit for non-negative doubles (add, sub, mul, div, half)
// radix-2 shift-add multiply, restoring divide, bitwise normalise, round to nearest even
// depends on nds_pkg
`default_nettype none

module nds_fpu import nds_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire fpu_req_t req_i,
  output fpu_rsp_t      rsp_o
);

  localparam logic [3:0] F_IDLE  = 4'd0;
  localparam logic [3:0] F_PRE   = 4'd1;
  localparam logic [3:0] F_MUL   = 4'd2;
  localparam logic [3:0] F_DIV   = 4'd3;
  localparam logic [3:0] F_ALIGN = 4'd4;
  localparam logic [3:0] F_SUM   = 4'd5;
  localparam logic [3:0] F_NORM  = 4'd6;
  localparam logic [3:0] F_DEN   = 4'd7;
  localparam logic [3:0] F_RND   = 4'd8;

  logic [3:0]             state_r, state_nxt;
  fpu_op_t                op_r, op_nxt;
  logic [MAN_W-1:0]       ma_r, ma_nxt, mb_r, mb_nxt;
  logic signed [EW-1:0]   ea_r, ea_nxt, eb_r, eb_nxt;
  logic [MAN_W:0]         acc_r, acc_nxt;
  logic [DBL_W-1:0]       w_r, w_nxt, bw_r, bw_nxt;
  logic                   sticky_r, sticky_nxt;
  logic signed [EW-1:0]   e_r, e_nxt;
  logic [5:0]             cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;
  logic [DBL_W-1:0]       res_r, res_nxt;

  // operand unpacking
  logic [EXP_W-1:0]     a_exp, b_exp;
  logic [MAN_W-1:0]     a_man, b_man;
  logic signed [EW-1:0] a_e, b_e;
  logic                 swap;

  assign a_exp = req_i.a[62:52];
  assign b_exp = req_i.b[62:52];
  assign a_man = {a_exp != '0, req_i.a[51:0]};
  assign b_man = {b_exp != '0, req_i.b[51:0]};
  assign a_e   = (a_exp == '0) ? EW'(1) : $signed({3'b000, a_exp});
  assign b_e   = (b_exp == '0) ? EW'(1) : $signed({3'b000, b_exp});
  assign swap  = (req_i.op == OP_ADD) && (req_i.b[62:0] > req_i.a[62:0]);

  // working terms
  logic [MAN_W:0]       mul_sum, div_rt;
  logic                 div_ge;
  logic [DBL_W-1:0]     mul_w;
  logic signed [EW-1:0] d_exp, den_sh;
  logic [DBL_W-1:0]     b_full, lost_mask, den_mask;
  logic [DBL_W:0]       sum65;
  logic [MAN_W-1:0]     rnd_mant;
  logic [MAN_W:0]       rnd_m54;
  logic                 rnd_up;
  logic signed [EW-1:0] rnd_e;

  always_comb begin
    mul_sum   = acc_r + {1'b0, (mb_r[0] ? ma_r : '0)};
    mul_w     = {mul_sum[0], w_r[63:1]};
    div_ge    = acc_r >= {1'b0, mb_r};
    div_rt    = div_ge ? (acc_r - {1'b0, mb_r}) : acc_r;
    d_exp     = ea_r - eb_r;
    b_full    = {mb_r, 11'b0};
    lost_mask = (64'd1 << d_exp[5:0]) - 64'd1;
    sum65     = {1'b0, w_r} + {1'b0, bw_r};
    den_sh    = EW'(1) - e_r;
    den_mask  = (64'd1 << den_sh[5:0]) - 64'd1;
    rnd_up    = w_r[10] & ((|w_r[9:0]) | sticky_r | w_r[11]);
    rnd_m54   = {1'b0, w_r[63:11]} + {{MAN_W{1'b0}}, rnd_up};
    if (rnd_m54[MAN_W]) begin
      rnd_mant = {1'b1, {FRAC_W{1'b0}}};
      rnd_e    = e_r + EW'(1);
    end else begin
      rnd_mant = rnd_m54[MAN_W-1:0];
      rnd_e    = e_r;
    end
  end

  // sequencer of the unit
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    ma_nxt     = ma_r;
    mb_nxt     = mb_r;
    ea_nxt     = ea_r;
    eb_nxt     = eb_r;
    acc_nxt    = acc_r;
    w_nxt      = w_r;
    bw_nxt     = bw_r;
    sticky_nxt = sticky_r;
    e_nxt      = e_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    res_nxt    = res_r;
    unique case (state_r)
      F_IDLE: begin
        if (req_i.start) begin
          op_nxt     = req_i.op;
          ma_nxt     = swap ? b_man : a_man;
          mb_nxt     = swap ? a_man : b_man;
          ea_nxt     = swap ? b_e : a_e;
          eb_nxt     = swap ? a_e : b_e;
          cnt_nxt    = '0;
          acc_nxt    = '0;
          w_nxt      = '0;
          sticky_nxt = 1'b0;
          case (req_i.op) inside
            OP_ADD, OP_SUB: state_nxt = F_ALIGN;
            OP_MUL, OP_DIV: state_nxt = F_PRE;
            default: begin
              w_nxt     = {a_man, 11'b0};
              e_nxt     = a_e - EW'(1);
              state_nxt = F_NORM;
            end
          endcase
        end
      end
      // bring subnormal significands to a leading one
      F_PRE: begin
        if (!ma_r[MAN_W-1] && ma_r != '0) begin
          ma_nxt = {ma_r[MAN_W-2:0], 1'b0};
          ea_nxt = ea_r - EW'(1);
        end
        if (!mb_r[MAN_W-1] && mb_r != '0) begin
          mb_nxt = {mb_r[MAN_W-2:0], 1'b0};
          eb_nxt = eb_r - EW'(1);
        end
        if ((ma_r[MAN_W-1] || ma_r == '0) && (mb_r[MAN_W-1] || mb_r == '0)) begin
          cnt_nxt = '0;
          w_nxt   = '0;
          if (op_r == OP_MUL) begin
            acc_nxt   = '0;
            state_nxt = F_MUL;
          end else begin
            acc_nxt   = {1'b0, ma_r};
            state_nxt = F_DIV;
          end
        end
      end
      // one multiplier bit per cycle
      F_MUL: begin
        acc_nxt = {1'b0, mul_sum[MAN_W:1]};
        w_nxt   = mul_w;
        mb_nxt  = {1'b0, mb_r[MAN_W-1:1]};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(MAN_W - 1)) begin
          w_nxt      = {mul_sum[MAN_W:1], mul_w[63:53]};
          sticky_nxt = |mul_w[52:0];
          e_nxt      = ea_r + eb_r - EW'(1022);
          state_nxt  = F_NORM;
        end
      end
      // one quotient bit per cycle
      F_DIV: begin
        acc_nxt = {div_rt[MAN_W-1:0], 1'b0};
        w_nxt   = {w_r[62:0], div_ge};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          sticky_nxt = div_rt != '0;
          e_nxt      = ea_r - eb_r + EW'(1023);
          state_nxt  = F_NORM;
        end
      end
      // line up the smaller operand
      F_ALIGN: begin
        w_nxt = {ma_r, 11'b0};
        if (d_exp > EW'(63)) begin
          bw_nxt     = '0;
          sticky_nxt = |mb_r;
        end else begin
          bw_nxt     = b_full >> d_exp[5:0];
          sticky_nxt = |(b_full & lost_mask);
        end
        state_nxt = F_SUM;
      end
      F_SUM: begin
        if (op_r == OP_ADD) begin
          if (sum65[64]) begin
            w_nxt      = sum65[64:1];
            sticky_nxt = sticky_r | sum65[0];
            e_nxt      = ea_r + EW'(1);
          end else begin
            w_nxt = sum65[63:0];
            e_nxt = ea_r;
          end
        end else begin
          w_nxt = w_r - bw_r - {63'b0, sticky_r};
          e_nxt = ea_r;
        end
        state_nxt = F_NORM;
      end
      // left normalise one bit per cycle
      F_NORM: begin
        if (!w_r[63] && e_r > EW'(1) && w_r != '0) begin
          w_nxt = {w_r[62:0], 1'b0};
          e_nxt = e_r - EW'(1);
        end else begin
          state_nxt = F_DEN;
        end
      end
      // shift into the subnormal range
      F_DEN: begin
        if (e_r < EW'(1)) begin
          if (den_sh > EW'(63)) begin
            w_nxt      = '0;
            sticky_nxt = sticky_r | (|w_r);
          end else begin
            w_nxt      = w_r >> den_sh[5:0];
            sticky_nxt = sticky_r | (|(w_r & den_mask));
          end
          e_nxt = EW'(1);
        end
        state_nxt = F_RND;
      end
      F_RND: begin
        if (rnd_e > EW'(2046)) begin
          res_nxt = EXP_MASK;
        end else begin
          res_nxt = {1'b0, (rnd_mant[MAN_W-1] ? rnd_e[EXP_W-1:0] : {EXP_W{1'b0}}),
                     rnd_mant[FRAC_W-1:0]};
        end
        done_nxt  = 1'b1;
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    ma_r     <= ma_nxt;
    mb_r     <= mb_nxt;
    ea_r     <= ea_nxt;
    eb_r     <= eb_nxt;
    acc_r    <= acc_nxt;
    w_r      <= w_nxt;
    bw_r     <= bw_nxt;
    sticky_r <= sticky_nxt;
    e_r      <= e_nxt;
    cnt_r    <= cnt_nxt;
    res_r    <= res_nxt;
  end

  assign rsp_o.done = done_r;
  assign rsp_o.res  = res_r;

endmodule

`default_nettype wire

// ===== hw/rtl/newton_double_sqrt_core.sv =====
// newton_double_sqrt_core: double-precision square root by newton iteration
// sequencer around one shared iterative floating-point unit; depends on nds_pkg, nds_fpu
//
// usage
//   input channel: in_valid / in_stall / in_value_bits carries one ieee-754 double per
//   request. output channel: out_valid / out_stall / out_root_bits / out_status returns
//   one result per request (status 0 ok, 1 invalid argument, 2 range / no convergence).
//   in_stall is high from acceptance until the result has been moved into the output
//   register; one request is worked on at a time.
//   special inputs (nan, negative, zero, infinity) are answered without the shared unit.
//   other values run newton steps: each step runs a divide (prenormalise, then quotient
//   bits one at a time), an add, a halving, a subtract and, below one, a multiply
//   through the shared unit, plus normalise and round. moderate inputs converge in
//   under ten steps; extreme exponents take up to about 540 steps, bounded by MAX_STEPS.
//   the output register holds a result while out_stall is high; a new request is taken
//   meanwhile and its result waits until the output register is free.
//   reset (synchronous, active low) returns to idle with no result pending.
`default_nettype none

module newton_double_sqrt_core import nds_pkg::*; #(
  parameter int MAX_STEPS = 1000
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [DBL_W-1:0] in_value_bits,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [DBL_W-1:0]      out_root_bits,
  output logic [1:0]            out_status
);

  localparam int K_W = $clog2(MAX_STEPS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_ADD  = 4'd3;
  localparam logic [3:0] S_HALF = 4'd4;
  localparam logic [3:0] S_DIFF = 4'd5;
  localparam logic [3:0] S_TOL  = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic             wait_r, wait_nxt;
  logic [DBL_W-1:0] v_r, v_nxt, x_r, x_nxt, t_r, t_nxt, nx_r, nx_nxt;
  logic [DBL_W-1:0] d_r, d_nxt, tol_r, tol_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [DBL_W-1:0] res_root_r, res_root_nxt;
  logic [1:0]       res_st_r, res_st_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [DBL_W-1:0] out_root_r, out_root_nxt;
  logic [1:0]       out_st_r, out_st_nxt;

  fpu_req_t fpu_req;
  fpu_rsp_t fpu_rsp;

  nds_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (fpu_req),
    .rsp_o (fpu_rsp)
  );

  // input classification
  logic in_exp_ones, in_frac_nz, in_acc, nx_ge_x, res_nan, out_free;
  assign in_exp_ones = (in_value_bits & EXP_MASK) == EXP_MASK;
  assign in_frac_nz  = (in_value_bits & FRAC_MASK) != '0;
  assign in_acc      = in_valid && !in_stall;
  assign nx_ge_x     = nx_r[62:0] >= x_r[62:0];
  assign res_nan     = ((fpu_rsp.res & EXP_MASK) == EXP_MASK) &&
                       ((fpu_rsp.res & FRAC_MASK) != '0);
  assign out_free    = !out_valid_r || !out_stall;

  // request to the shared unit
  always_comb begin
    fpu_req.start = 1'b0;
    fpu_req.op    = OP_ADD;
    fpu_req.a     = x_r;
    fpu_req.b     = t_r;
    unique case (state_r)
      S_DIV: begin
        fpu_req.start = !wait_r;
        fpu_req.op    = OP_DIV;
        fpu_req.a     = v_r;
        fpu_req.b     = x_r;
      end
      S_ADD: begin
        fpu_req.start = !wait_r;
      end
      S_HALF: begin
        fpu_req.start = !wait_r;
        fpu_req.op    = OP_HALF;
        fpu_req.a     = t_r;
      end
      S_DIFF: begin
        fpu_req.start = !wait_r;
        fpu_req.op    = OP_SUB;
        fpu_req.a     = nx_ge_x ? nx_r : x_r;
        fpu_req.b     = nx_ge_x ? x_r : nx_r;
      end
      S_TOL: begin
        fpu_req.start = !wait_r;
        fpu_req.op    = OP_MUL;
        fpu_req.a     = nx_r;
        fpu_req.b     = TOL_REL;
      end
      default: fpu_req.start = 1'b0;
    endcase
  end

  // newton sequencer
  always_comb begin
    state_nxt     = state_r;
    wait_nxt      = wait_r;
    v_nxt         = v_r;
    x_nxt         = x_r;
    t_nxt         = t_r;
    nx_nxt        = nx_r;
    d_nxt         = d_r;
    tol_nxt       = tol_r;
    k_nxt         = k_r;
    res_root_nxt  = res_root_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_root_nxt  = out_root_r;
    out_st_nxt    = out_st_r;
    if (fpu_req.start) begin
      wait_nxt = 1'b1;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_OUT;
          if (in_exp_ones && in_frac_nz) begin
            res_root_nxt = QUIET_NAN;
            res_st_nxt   = ST_INVALID;
          end else if (in_value_bits[62:0] == '0) begin
            res_root_nxt = '0;
            res_st_nxt   = ST_OK;
          end else if (in_value_bits[63]) begin
            res_root_nxt = QUIET_NAN;
            res_st_nxt   = ST_INVALID;
          end else if (in_exp_ones) begin
            res_root_nxt = in_value_bits;
            res_st_nxt   = ST_OK;
          end else begin
            v_nxt     = in_value_bits;
            x_nxt     = in_value_bits;
            k_nxt     = '0;
            state_nxt = S_CHK;
          end
        end
      end
      // step limit and zero-estimate guard
      S_CHK: begin
        if (k_r == K_W'(MAX_STEPS) || x_r[62:0] == '0) begin
          res_root_nxt = QUIET_NAN;
          res_st_nxt   = ST_RANGE;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (wait_r && fpu_rsp.done) begin
          wait_nxt  = 1'b0;
          t_nxt     = fpu_rsp.res;
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        if (wait_r && fpu_rsp.done) begin
          wait_nxt  = 1'b0;
          t_nxt     = fpu_rsp.res;
          state_nxt = S_HALF;
        end
      end
      S_HALF: begin
        if (wait_r && fpu_rsp.done) begin
          wait_nxt = 1'b0;
          nx_nxt   = fpu_rsp.res;
          if (res_nan) begin
            res_root_nxt = QUIET_NAN;
            res_st_nxt   = ST_RANGE;
            state_nxt    = S_OUT;
          end else begin
            state_nxt = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        if (wait_r && fpu_rsp.done) begin
          wait_nxt = 1'b0;
          d_nxt    = fpu_rsp.res;
          if (nx_r[62:0] < DBL_ONE[62:0]) begin
            state_nxt = S_TOL;
          end else begin
            tol_nxt   = TOL_REL;
            state_nxt = S_CMP;
          end
        end
      end
      // relative tolerance with its floor
      S_TOL: begin
        if (wait_r && fpu_rsp.done) begin
          wait_nxt  = 1'b0;
          tol_nxt   = (fpu_rsp.res[62:0] < TOL_MIN[62:0]) ? TOL_MIN : fpu_rsp.res;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (d_r[62:0] < tol_r[62:0]) begin
          res_root_nxt = nx_r;
          res_st_nxt   = ST_OK;
          state_nxt    = S_OUT;
        end else begin
          x_nxt     = nx_r;
          k_nxt     = k_r + K_W'(1);
          state_nxt = S_CHK;
        end
      end
      // hand over to the output register
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_root_nxt  = res_root_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    x_r        <= x_nxt;
    t_r        <= t_nxt;
    nx_r       <= nx_nxt;
    d_r        <= d_nxt;
    tol_r      <= tol_nxt;
    k_r        <= k_nxt;
    res_root_r <= res_root_nxt;
    res_st_r   <= res_st_nxt;
    out_root_r <= out_root_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign in_stall      = state_r != S_IDLE;
  assign out_valid     = out_valid_r;
  assign out_root_bits = out_root_r;
  assign out_status    = out_st_r;

endmodule

`default_nettype wire
